// ===== hdl/sm3_pkg.sv =====
// sm3 hash engine package: states, initial value, round helper functions
// no dependencies
`default_nettype none

package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 64;

  localparam logic [WordW-1:0] TjLow  = 32'h79CC4519;
  localparam logic [WordW-1:0] TjHigh = 32'h7A879D8A;
  localparam logic [WordW-1:0] PadWord = 32'h80000000;

  localparam logic [WordW-1:0] Iv [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } sm3_state_e;

  function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] x, input logic [4:0] n);
    logic [2*WordW-1:0] t;
    t = {x, x} << n;
    return t[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

  // keeps the first nv bytes and appends the 0x80 marker after them
  function automatic logic [WordW-1:0] tail_word(input logic [WordW-1:0] w,
                                                 input logic [1:0] nv);
    logic [WordW-1:0] r;
    unique case (nv)
      2'd0: r = PadWord;
      2'd1: r = {w[31:24], 24'h800000};
      2'd2: r = {w[31:16], 16'h8000};
      2'd3: r = {w[31:8], 8'h80};
      default: r = PadWord;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sm3_stream_if.sv =====
// sm3 stream interfaces: message word channel and digest word channel
// depends on nothing
`default_nettype none

interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  bytes_valid;
  logic        last_word;
  modport source (output valid, message_word, bytes_valid, last_word, input ready);
  modport sink (input valid, message_word, bytes_valid, last_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sm3_hash_engine.sv =====
// SM3 hash engine top level: one shared round unit under a small sequencer.
// The message arrives one big-endian word per handshake, and every 16th word (and the padding
// of the last block) starts a compression, one round per cycle, followed by a fold of the
// working state into the chaining value. The input is not ready while a compression, the
// fold, the padding words or the eight digest words run.
// Depends on sm3_pkg and sm3_stream_if.
`default_nettype none

module sm3_hash_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sm3_in_if.sink     msg_i,
  sm3_out_if.source  dig_o
);

  sm3_pkg::sm3_state_e state_q, state_d;

  logic [31:0] chain_q [8];
  logic [31:0] wr_q    [8];
  logic [31:0] w_q     [16];
  logic [3:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        fin_q, need80_q, lenok_q, done_q;

  logic        in_acc, out_acc;
  logic [2:0]  nv;
  logic [31:0] pad_w;
  logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, wnew;

  assign in_acc  = msg_i.valid && msg_i.ready;
  assign out_acc = dig_o.valid && dig_o.ready;
  assign nv = (!msg_i.last_word || msg_i.bytes_valid > 3'd4) ? 3'd4 : msg_i.bytes_valid;

  assign msg_i.ready       = (state_q == sm3_pkg::ST_IDLE);
  assign dig_o.valid       = (state_q == sm3_pkg::ST_OUT);
  assign dig_o.digest_word = chain_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.digest_last = (idx_q == 3'd7);

  always_comb begin
    if (need80_q) begin
      pad_w = sm3_pkg::PadWord;
    end else if (lenok_q && fill_q == 4'd14) begin
      pad_w = len_q[63:32];
    end else if (lenok_q && fill_q == 4'd15) begin
      pad_w = len_q[31:0];
    end else begin
      pad_w = '0;
    end
  end

  always_comb begin
    a12 = sm3_pkg::rol(wr_q[0], 5'd12);
    tj  = (rnd_q < 6'd16) ? sm3_pkg::TjLow : sm3_pkg::TjHigh;
    ss1 = sm3_pkg::rol(a12 + wr_q[4] + sm3_pkg::rol(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = wr_q[0] ^ wr_q[1] ^ wr_q[2];
      gg = wr_q[4] ^ wr_q[5] ^ wr_q[6];
    end else begin
      ff = (wr_q[0] & wr_q[1]) | (wr_q[0] & wr_q[2]) | (wr_q[1] & wr_q[2]);
      gg = (wr_q[4] & wr_q[5]) | (~wr_q[4] & wr_q[6]);
    end
    tt1  = ff + wr_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2  = gg + wr_q[7] + ss1 + w_q[0];
    wnew = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol(w_q[13], 5'd15))
           ^ sm3_pkg::rol(w_q[3], 5'd7) ^ w_q[10];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sm3_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (fill_q == 4'd15) begin
            state_d = sm3_pkg::ST_COMP;
          end else if (msg_i.last_word) begin
            state_d = sm3_pkg::ST_PAD;
          end
        end
      end
      sm3_pkg::ST_PAD: begin
        if (fill_q == 4'd15) begin
          state_d = sm3_pkg::ST_COMP;
        end
      end
      sm3_pkg::ST_COMP: begin
        if (rnd_q == 6'd63) begin
          state_d = sm3_pkg::ST_FOLD;
        end
      end
      sm3_pkg::ST_FOLD: begin
        if (!fin_q) begin
          state_d = sm3_pkg::ST_IDLE;
        end else if (done_q) begin
          state_d = sm3_pkg::ST_OUT;
        end else begin
          state_d = sm3_pkg::ST_PAD;
        end
      end
      sm3_pkg::ST_OUT: begin
        if (out_acc && idx_q == 3'd7) begin
          state_d = sm3_pkg::ST_IDLE;
        end
      end
      default: state_d = sm3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sm3_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= sm3_pkg::Iv;
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      need80_q <= 1'b0;
      lenok_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      unique case (state_q)
        sm3_pkg::ST_IDLE: begin
          if (in_acc) begin
            len_q  <= len_q + {58'd0, nv, 3'd0};
            fill_q <= fill_q + 4'd1;
            if (msg_i.last_word) begin
              fin_q <= 1'b1;
              if (nv == 3'd4) begin
                w_q[fill_q] <= msg_i.message_word;
                need80_q    <= 1'b1;
              end else begin
                w_q[fill_q] <= sm3_pkg::tail_word(msg_i.message_word, nv[1:0]);
                lenok_q     <= (fill_q <= 4'd13);
              end
            end else begin
              w_q[fill_q] <= msg_i.message_word;
            end
            if (fill_q == 4'd15) begin
              wr_q <= chain_q;
            end
          end
        end
        sm3_pkg::ST_PAD: begin
          w_q[fill_q] <= pad_w;
          fill_q      <= fill_q + 4'd1;
          if (need80_q) begin
            need80_q <= 1'b0;
            lenok_q  <= (fill_q <= 4'd13);
          end
          if (!need80_q && lenok_q && fill_q == 4'd15) begin
            done_q <= 1'b1;
          end
          if (fill_q == 4'd15) begin
            wr_q <= chain_q;
          end
        end
        sm3_pkg::ST_COMP: begin
          wr_q[3] <= wr_q[2];
          wr_q[2] <= sm3_pkg::rol(wr_q[1], 5'd9);
          wr_q[1] <= wr_q[0];
          wr_q[0] <= tt1;
          wr_q[7] <= wr_q[6];
          wr_q[6] <= sm3_pkg::rol(wr_q[5], 5'd19);
          wr_q[5] <= wr_q[4];
          wr_q[4] <= sm3_pkg::perm0(tt2);
          for (int i = 0; i < 15; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[15] <= wnew;
          rnd_q   <= rnd_q + 6'd1;
        end
        sm3_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] ^ wr_q[i];
          end
          if (fin_q && !need80_q) begin
            lenok_q <= 1'b1;
          end
        end
        sm3_pkg::ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              chain_q  <= sm3_pkg::Iv;
              fill_q   <= '0;
              len_q    <= '0;
              fin_q    <= 1'b0;
              need80_q <= 1'b0;
              lenok_q  <= 1'b0;
              done_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // digest words never overlap message intake
  assert property (@(posedge clk_i) disable iff (!rst_ni) dig_o.valid |-> !msg_i.ready)
    else $error("digest valid while accepting input");

  // round counter rests at zero outside a compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sm3_pkg::ST_COMP) |-> (rnd_q == 6'd0))
    else $error("round counter not idle");

  // last digest word rearms the length counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && dig_o.digest_last) |=> (len_q == 64'd0 && fill_q == 4'd0))
    else $error("message state not cleared");

  // a compression always runs 64 rounds then folds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sm3_pkg::ST_COMP && rnd_q == 6'd63) |=> (state_q == sm3_pkg::ST_FOLD))
    else $error("compression length wrong");

endmodule

`default_nettype wire
